// ===== src/bfd_pkg.sv =====
// shared types and constants for the box filter downscaler
// no dependencies
package bfd_pkg;

  localparam int MAX_SOURCE_SIDE = 768;
  localparam int MAX_DEST_WIDTH  = 64;

  localparam int SIDE_W  = 10;
  localparam int DW_W    = 7;
  localparam int CH_W    = 3;
  localparam int COL_W   = $clog2(MAX_DEST_WIDTH);
  localparam int CHAN_W  = 8;
  localparam int PIXEL_W = 32;
  localparam int SUM_W   = 28;
  localparam int CNT_W   = 20;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int STEP_W  = 4;

  // register indexes
  localparam logic [2:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [2:0] REG_DST_WIDTH  = 3'd2;
  localparam logic [2:0] REG_DST_HEIGHT = 3'd3;
  localparam logic [2:0] REG_CHANNELS   = 3'd4;

  localparam logic [CHAN_W-1:0] OPAQUE = 8'd255;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [SUM_W-1:0] alpha;
    logic [SUM_W-1:0] blue;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] red;
  } acc_t;

  typedef struct packed {
    logic prep_start;
    logic prep_step;
    logic prep_init;
    logic acc_rd;
    logic acc_wr;
    logic em_rd;
    logic em_load;
    logic em_step;
    logic em_put;
  } dp_cmd_t;

  typedef struct packed {
    logic prep_done;
    logic band_end;
    logic div_done;
    logic last_col;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== src/bfd_ifs.sv =====
// request channel interfaces: source pixels in, packed pixels out
// depends on bfd_pkg
interface bfd_pix_if import bfd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;
  logic [CHAN_W-1:0] alpha;
  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink (input valid, red, green, blue, alpha, output ready);
endinterface

interface bfd_res_if import bfd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel;
  logic               row_end;
  logic               frame_end;
  modport source (output valid, pixel, row_end, frame_end, input ready);
  modport sink (input valid, pixel, row_end, frame_end, output ready);
endinterface

// ===== src/bfd_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module bfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/bfd_ctrl.sv =====
// sequencer: setup divide, per-pixel accumulate, per-band emission
// depends on bfd_pkg
module bfd_ctrl import bfd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     restart,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);
  typedef enum logic [2:0] {
    S_PREP_START, S_PREP, S_IDLE, S_ACC, S_EM_RD, S_EM_LD, S_EM_DIV, S_EM_PUT
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_PREP_START: begin
        cmd.prep_start = 1'b1;
        state_next = S_PREP;
      end
      S_PREP: begin
        if (stat.prep_done) begin
          cmd.prep_init = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.prep_step = 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.acc_rd = 1'b1;
          state_next = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc_wr = 1'b1;
        state_next = stat.band_end ? S_EM_RD : S_IDLE;
      end
      S_EM_RD: begin
        cmd.em_rd = 1'b1;
        state_next = S_EM_LD;
      end
      S_EM_LD: begin
        cmd.em_load = 1'b1;
        state_next = S_EM_DIV;
      end
      S_EM_DIV: begin
        if (stat.div_done) begin
          state_next = S_EM_PUT;
        end else begin
          cmd.em_step = 1'b1;
        end
      end
      S_EM_PUT: begin
        if (stat.out_free) begin
          cmd.em_put = 1'b1;
          state_next = stat.last_col ? S_IDLE : S_EM_RD;
        end
      end
      default: state_next = S_PREP_START;
    endcase
    if (restart) begin
      cmd = '0;
      state_next = S_PREP_START;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_PREP_START;
    end else begin
      state <= state_next;
    end
  end
endmodule

// ===== src/bfd_datapath.sv =====
// position tracking, accumulator ram, edge stepping and averaging dividers
// depends on bfd_pkg and bfd_ram
module bfd_datapath import bfd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  input  logic [SIDE_W-1:0]  sw,
  input  logic [SIDE_W-1:0]  sh,
  input  logic [DW_W-1:0]    tw,
  input  logic [SIDE_W-1:0]  th,
  input  logic               alpha_on,
  input  logic [CHAN_W-1:0]  red,
  input  logic [CHAN_W-1:0]  green,
  input  logic [CHAN_W-1:0]  blue,
  input  logic [CHAN_W-1:0]  alpha,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [PIXEL_W-1:0] pixel,
  output logic               row_end,
  output logic               frame_end
);
  localparam int ACC_W = $bits(acc_t);
  localparam int QW    = CHAN_W;
  localparam int DSR_W = CNT_W + QW - 1;

  // setup dividers: sw/tw and sh/th
  logic [SIDE_W-1:0] pc_quo, pr_quo;
  logic [DW_W-1:0]   pc_rem;
  logic [SIDE_W-1:0] pr_rem;
  logic [STEP_W-1:0] step;
  logic [DW_W:0]     col_sh;
  logic [SIDE_W:0]   row_sh;
  logic              col_ge, row_ge;

  // frame position
  logic [SIDE_W-1:0] q_col, q_row, source_x, source_y, dest_row;
  logic [SIDE_W-1:0] column_edge, row_edge, row_rem, r_row;
  logic [DW_W-1:0]   col_rem, r_col;
  logic [COL_W-1:0]  band_column, ecol;

  logic [DW_W:0]     col_rsum;
  logic              col_carry, advance;
  logic [COL_W-1:0]  col_next;
  logic [SIDE_W:0]   row_rsum;
  logic              row_carry, last_row;
  logic [SIDE_W-1:0] row_edge_adv;

  // accumulator storage, valid bits stand in for clearing
  logic [MAX_DEST_WIDTH-1:0] valid;
  logic                      rd_ok;
  logic [COL_W-1:0]          raddr;
  acc_t                      rdata, acc_cur, acc_new;
  logic [CHAN_W-1:0]         p_red, p_green, p_blue, p_alpha;

  // averaging lanes: red, green, blue, alpha
  logic [SUM_W-1:0] rem [4];
  logic [QW-1:0]    quo [4];
  logic [DSR_W-1:0] dsr;
  logic [CNT_W-1:0] cnt_eff;

  assign col_sh = {pc_rem, pc_quo[SIDE_W-1]};
  assign row_sh = {pr_rem, pr_quo[SIDE_W-1]};
  assign col_ge = col_sh >= {1'b0, tw};
  assign row_ge = row_sh >= {1'b0, th};

  assign col_rsum  = {1'b0, col_rem} + {1'b0, r_col};
  assign col_carry = col_rsum >= {1'b0, tw};
  assign advance   = (source_x >= column_edge) &&
                     ({1'b0, band_column} + 7'd1 < tw);
  assign col_next  = advance ? band_column + COL_W'(1) : band_column;

  assign row_rsum     = {1'b0, row_rem} + {1'b0, r_row};
  assign row_carry    = row_rsum >= {1'b0, th};
  assign row_edge_adv = row_edge + q_row + SIDE_W'(row_carry);
  assign last_row     = ({1'b0, dest_row} + 11'd1) >= {1'b0, th};

  assign raddr   = cmd.em_rd ? ecol : col_next;
  assign acc_cur = rd_ok ? rdata : '0;

  always_comb begin
    acc_new       = acc_cur;
    acc_new.red   = acc_cur.red + SUM_W'(p_red);
    acc_new.green = acc_cur.green + SUM_W'(p_green);
    acc_new.blue  = acc_cur.blue + SUM_W'(p_blue);
    acc_new.alpha = acc_cur.alpha + SUM_W'(p_alpha);
    acc_new.cnt   = acc_cur.cnt + CNT_W'(1);
  end

  assign cnt_eff = (acc_cur.cnt == '0) ? CNT_W'(1) : acc_cur.cnt;

  bfd_ram #(.WIDTH(ACC_W), .DEPTH(MAX_DEST_WIDTH)) u_acc_ram (
    .clk   (clk),
    .we    (cmd.acc_wr),
    .waddr (band_column),
    .wdata (acc_new),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign stat.prep_done = (step == STEP_W'(SIDE_W));
  assign stat.div_done  = (step == STEP_W'(QW));
  assign stat.band_end  = (({1'b0, source_x} + 11'd1) == {1'b0, sw}) &&
                          (({1'b0, source_y} + 11'd1) >= {1'b0, row_edge});
  assign stat.last_col  = ({1'b0, ecol} + 7'd1) == tw;
  assign stat.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    rd_ok <= valid[raddr];

    if (cmd.prep_start || cmd.em_load) begin
      step <= '0;
    end else if (cmd.prep_step || cmd.em_step) begin
      step <= step + STEP_W'(1);
    end

    // restoring division, one quotient bit per step
    if (cmd.prep_start) begin
      pc_quo <= sw;
      pr_quo <= sh;
      pc_rem <= '0;
      pr_rem <= '0;
    end else if (cmd.prep_step) begin
      pc_quo <= {pc_quo[SIDE_W-2:0], col_ge};
      pr_quo <= {pr_quo[SIDE_W-2:0], row_ge};
      pc_rem <= col_ge ? DW_W'(col_sh - {1'b0, tw}) : col_sh[DW_W-1:0];
      pr_rem <= row_ge ? SIDE_W'(row_sh - {1'b0, th}) : row_sh[SIDE_W-1:0];
    end

    if (cmd.prep_init) begin
      q_col       <= pc_quo;
      r_col       <= pc_rem;
      q_row       <= pr_quo;
      r_row       <= pr_rem;
      column_edge <= pc_quo;
      col_rem     <= pc_rem;
      row_edge    <= pr_quo;
      row_rem     <= pr_rem;
      source_x    <= '0;
      source_y    <= '0;
      band_column <= '0;
      dest_row    <= '0;
      ecol        <= '0;
    end

    if (cmd.acc_rd) begin
      p_red   <= red;
      p_green <= green;
      p_blue  <= blue;
      p_alpha <= alpha_on ? alpha : OPAQUE;
      if (advance) begin
        band_column <= col_next;
        column_edge <= column_edge + q_col + SIDE_W'(col_carry);
        col_rem     <= col_carry ? DW_W'(col_rsum - {1'b0, tw}) : col_rsum[DW_W-1:0];
      end
    end

    if (cmd.acc_wr) begin
      if (({1'b0, source_x} + 11'd1) == {1'b0, sw}) begin
        source_x    <= '0;
        band_column <= '0;
        column_edge <= q_col;
        col_rem     <= r_col;
        source_y    <= source_y + SIDE_W'(1);
      end else begin
        source_x <= source_x + SIDE_W'(1);
      end
    end

    if (cmd.em_load) begin
      rem[0] <= acc_cur.red;
      rem[1] <= acc_cur.green;
      rem[2] <= acc_cur.blue;
      rem[3] <= acc_cur.alpha;
      dsr    <= {cnt_eff, (QW-1)'(0)};
    end else if (cmd.em_step) begin
      for (int i = 0; i < 4; i++) begin
        if ({1'b0, rem[i]} >= (SUM_W+1)'(dsr)) begin
          rem[i] <= rem[i] - SUM_W'(dsr);
          quo[i] <= {quo[i][QW-2:0], 1'b1};
        end else begin
          quo[i] <= {quo[i][QW-2:0], 1'b0};
        end
      end
      dsr <= dsr >> 1;
    end

    if (cmd.em_put) begin
      pixel     <= {quo[3], quo[2], quo[1], quo[0]};
      row_end   <= stat.last_col;
      frame_end <= stat.last_col && last_row;
      if (stat.last_col) begin
        ecol <= '0;
        if (last_row) begin
          source_y <= '0;
          dest_row <= '0;
          row_edge <= q_row;
          row_rem  <= r_row;
        end else begin
          dest_row <= dest_row + SIDE_W'(1);
          row_edge <= row_edge_adv;
          row_rem  <= row_carry ? SIDE_W'(row_rsum - {1'b0, th}) : row_rsum[SIDE_W-1:0];
        end
      end else begin
        ecol <= ecol + COL_W'(1);
      end
    end

    if (rst) begin
      valid     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.prep_init || (cmd.em_put && stat.last_col)) begin
        valid <= '0;
      end else if (cmd.acc_wr) begin
        valid[band_column] <= 1'b1;
      end
      if (cmd.em_put) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule

// ===== src/box_filter_downscale_rgba_core.sv =====
// box filter downscaler top level: apb registers, sequencer and datapath
// depends on bfd_pkg, bfd_ifs, bfd_ctrl, bfd_datapath
// each pixel request is a ram read, then an add and write back
// a band's last pixel starts emission: each result is a read, a load,
// 8 divide steps, a done check and a put, one result per destination column
// reset and every write inside the register list run the setup divide, ready low
// reset is synchronous and restores the default 768x768 -> 64x64 rgba setup
module box_filter_downscale_rgba_core import bfd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  bfd_pix_if.sink           pixels,
  bfd_res_if.source         results
);
  // configuration registers
  logic [SIDE_W-1:0] src_width, src_height, dst_height;
  logic [DW_W-1:0]   dst_width;
  logic [CH_W-1:0]   channels;

  // effective sizes after clamping
  logic [SIDE_W-1:0] sw, sh, th, tw_wide, tw_raw;
  logic [DW_W-1:0]   tw;
  logic              alpha_on;

  logic     wr_fire, restart;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign pready  = 1'b1;
  assign wr_fire = psel && penable && pwrite;
  // only writes inside the register list restart the frame
  assign restart = wr_fire && (paddr[4:2] <= REG_CHANNELS);

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= SIDE_W'(MAX_SOURCE_SIDE);
      src_height <= SIDE_W'(MAX_SOURCE_SIDE);
      dst_width  <= DW_W'(MAX_DEST_WIDTH);
      dst_height <= SIDE_W'(64);
      channels   <= CH_W'(4);
    end else if (wr_fire) begin
      case (paddr[4:2])
        REG_SRC_WIDTH:  src_width  <= pwdata[SIDE_W-1:0];
        REG_SRC_HEIGHT: src_height <= pwdata[SIDE_W-1:0];
        REG_DST_WIDTH:  dst_width  <= pwdata[DW_W-1:0];
        REG_DST_HEIGHT: dst_height <= pwdata[SIDE_W-1:0];
        REG_CHANNELS:   channels   <= pwdata[CH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_SRC_WIDTH:  prdata = DATA_W'(src_width);
      REG_SRC_HEIGHT: prdata = DATA_W'(src_height);
      REG_DST_WIDTH:  prdata = DATA_W'(dst_width);
      REG_DST_HEIGHT: prdata = DATA_W'(dst_height);
      REG_CHANNELS:   prdata = DATA_W'(channels);
      default:        prdata = '0;
    endcase
  end

  // zero counts as one, sources cap at the max side, targets never enlarge
  always_comb begin
    sw = (src_width == '0) ? SIDE_W'(1) :
         (src_width > SIDE_W'(MAX_SOURCE_SIDE)) ? SIDE_W'(MAX_SOURCE_SIDE) : src_width;
    sh = (src_height == '0) ? SIDE_W'(1) :
         (src_height > SIDE_W'(MAX_SOURCE_SIDE)) ? SIDE_W'(MAX_SOURCE_SIDE) : src_height;
    tw_raw  = (dst_width == '0) ? SIDE_W'(1) : SIDE_W'(dst_width);
    tw_wide = (tw_raw > SIDE_W'(MAX_DEST_WIDTH)) ? SIDE_W'(MAX_DEST_WIDTH) : tw_raw;
    if (tw_wide > sw) begin
      tw_wide = sw;
    end
    tw = tw_wide[DW_W-1:0];
    th = (dst_height == '0) ? SIDE_W'(1) : dst_height;
    if (th > sh) begin
      th = sh;
    end
    alpha_on = channels >= CH_W'(4);
  end

  bfd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .restart  (restart),
    .in_valid (pixels.valid),
    .in_ready (pixels.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bfd_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .sw        (sw),
    .sh        (sh),
    .tw        (tw),
    .th        (th),
    .alpha_on  (alpha_on),
    .red       (pixels.red),
    .green     (pixels.green),
    .blue      (pixels.blue),
    .alpha     (pixels.alpha),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .pixel     (results.pixel),
    .row_end   (results.row_end),
    .frame_end (results.frame_end)
  );
endmodule

// ===== src/bfd_checker.sv =====
// port-level checks for the box filter downscaler
// depends on bfd_pkg; bound to box_filter_downscale_rgba_core
module bfd_checker import bfd_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [ADDR_W-1:0]  paddr,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [PIXEL_W-1:0] pixel,
  input logic               row_end,
  input logic               frame_end
);
  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel))
    else $error("result changed while stalled");

  a_frame_row: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> row_end)
    else $error("frame end without row end");

  a_reset_setup: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("ready right after reset");

  a_cfg_setup: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && (paddr[4:2] <= REG_CHANNELS) |=> !in_ready)
    else $error("ready right after register write");
endmodule

bind box_filter_downscale_rgba_core bfd_checker u_bfd_checker (
  .clk       (clk),
  .rst       (rst),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .in_ready  (pixels.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .pixel     (results.pixel),
  .row_end   (results.row_end),
  .frame_end (results.frame_end)
);

// ===== tb/box_filter_downscale_rgba_core_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for box_filter_downscale_rgba_core
// depends on bfd_pkg, bfd_ifs and the core; drives pixels and registers, checks results
module box_filter_downscale_rgba_core_tb;
  import bfd_pkg::*;

  typedef struct {
    logic [CHAN_W-1:0] red, green, blue, alpha;
  } src_pixel_t;

  typedef struct {
    logic [PIXEL_W-1:0] pixel;
    logic               row_end;
    logic               frame_end;
  } dst_pixel_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  bfd_pix_if pixels ();
  bfd_res_if results ();

  box_filter_downscale_rgba_core dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .pixels(pixels.sink), .results(results.source)
  );

  always #4 clk = ~clk;

  // stimulus and expectations
  src_pixel_t pending_pixels[$];
  dst_pixel_t expected_pixels[$];
  int         error_count = 0;
  int         items_sent = 0;
  int         items_queued = 0;
  bit         calm = 1'b0;  // no idling on either side

  // register copies and the derived sizes in use
  logic [SIDE_W-1:0] reg_sw = 10'd768, reg_sh = 10'd768, reg_th = 10'd64;
  logic [DW_W-1:0]   reg_tw = 7'd64;
  logic [CH_W-1:0]   reg_ch = 3'd4;
  int unsigned       use_sw, use_sh, use_tw, use_th;

  // accumulator copy, one entry per destination column
  logic [SUM_W-1:0] sum_r[MAX_DEST_WIDTH], sum_g[MAX_DEST_WIDTH];
  logic [SUM_W-1:0] sum_b[MAX_DEST_WIDTH], sum_a[MAX_DEST_WIDTH];
  logic [CNT_W-1:0] box_count[MAX_DEST_WIDTH];
  int unsigned      pos_x, pos_y, box_col, out_row, col_edge, row_edge;

  function automatic int unsigned clamp_side(int unsigned v);
    if (v == 0) return 1;
    return v > MAX_SOURCE_SIDE ? MAX_SOURCE_SIDE : v;
  endfunction

  function automatic void clear_boxes();
    for (int i = 0; i < MAX_DEST_WIDTH; i++) begin
      sum_r[i] = '0; sum_g[i] = '0; sum_b[i] = '0; sum_a[i] = '0;
      box_count[i] = '0;
    end
  endfunction

  // any register write: recompute sizes and start a fresh frame
  function automatic void restart_frame();
    use_sw = clamp_side(reg_sw);
    use_sh = clamp_side(reg_sh);
    use_tw = reg_tw == 0 ? 1 : reg_tw;
    if (use_tw > MAX_DEST_WIDTH) use_tw = MAX_DEST_WIDTH;
    if (use_tw > use_sw) use_tw = use_sw;
    use_th = reg_th == 0 ? 1 : reg_th;
    if (use_th > use_sh) use_th = use_sh;
    clear_boxes();
    pos_x = 0; pos_y = 0; box_col = 0; out_row = 0;
    col_edge = use_sw / use_tw;
    row_edge = use_sh / use_th;
  endfunction

  // fold one source pixel into its box; a band's last pixel yields a row
  function automatic void downscale_pixel(src_pixel_t p);
    int unsigned c;
    bit          last_row;
    dst_pixel_t  d;
    while (pos_x >= col_edge && box_col + 1 < use_tw) begin
      box_col++;
      col_edge = (box_col + 1) * use_sw / use_tw;
    end
    sum_r[box_col] += p.red;
    sum_g[box_col] += p.green;
    sum_b[box_col] += p.blue;
    sum_a[box_col] += (reg_ch >= 4) ? p.alpha : OPAQUE;
    box_count[box_col] += 1;
    pos_x++;
    if (pos_x < use_sw) return;
    pos_x = 0; box_col = 0; col_edge = use_sw / use_tw;
    pos_y++;
    if (pos_y < row_edge) return;
    last_row = (out_row + 1 >= use_th);
    for (int k = 0; k < use_tw; k++) begin
      c = box_count[k] == 0 ? 1 : box_count[k];
      d.pixel[31:24] = 8'(sum_a[k] / c);
      d.pixel[23:16] = 8'(sum_b[k] / c);
      d.pixel[15:8]  = 8'(sum_g[k] / c);
      d.pixel[7:0]   = 8'(sum_r[k] / c);
      d.row_end   = (k + 1 == use_tw);
      d.frame_end = d.row_end && last_row;
      expected_pixels.push_back(d);
    end
    clear_boxes();
    if (last_row) begin
      pos_y = 0; out_row = 0; row_edge = use_sh / use_th;
    end else begin
      out_row++;
      row_edge = (out_row + 1) * use_sh / use_th;
    end
  endfunction

  task automatic report(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    error_count++;
  endtask

  // pixel driver: requests come from the pending queue, with idle bursts
  int src_gap = 0;
  always @(posedge clk) begin
    bit busy;
    src_pixel_t p;
    if (rst) begin
      pixels.valid <= 1'b0;
    end else begin
      busy = pixels.valid;
      if (pixels.valid && pixels.ready) begin
        p.red = pixels.red; p.green = pixels.green;
        p.blue = pixels.blue; p.alpha = pixels.alpha;
        downscale_pixel(p);
        items_sent++;
        busy = 1'b0;
        if (!calm && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 9);
      end
      if (!busy) begin
        if (src_gap > 0) begin
          src_gap--;
          pixels.valid <= 1'b0;
        end else if (pending_pixels.size() > 0) begin
          p = pending_pixels.pop_front();
          pixels.red <= p.red; pixels.green <= p.green;
          pixels.blue <= p.blue; pixels.alpha <= p.alpha;
          pixels.valid <= 1'b1;
        end else begin
          pixels.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: random stall bursts on ready, check against oldest expectation
  int sink_gap = 0;
  always @(posedge clk) begin
    dst_pixel_t d;
    if (rst) begin
      results.ready <= 1'b0;
    end else begin
      if (results.valid && results.ready) begin
        if (expected_pixels.size() == 0) begin
          report($sformatf("unexpected result %h", results.pixel));
        end else begin
          d = expected_pixels.pop_front();
          if (results.pixel !== d.pixel)
            report($sformatf("pixel %h, want %h", results.pixel, d.pixel));
          if (results.row_end !== d.row_end)
            report($sformatf("row_end %b, want %b", results.row_end, d.row_end));
          if (results.frame_end !== d.frame_end)
            report($sformatf("frame_end %b, want %b", results.frame_end, d.frame_end));
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        results.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        sink_gap = $urandom_range(0, 8);
        results.ready <= 1'b0;
      end else begin
        results.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no request, result or register access accepted
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (pixels.valid && pixels.ready) || (results.valid && results.ready)
        || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= 5000) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic reg_write(logic [2:0] index, logic [DATA_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'(index * 4); pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (index)
      REG_SRC_WIDTH:  reg_sw = value[SIDE_W-1:0];
      REG_SRC_HEIGHT: reg_sh = value[SIDE_W-1:0];
      REG_DST_WIDTH:  reg_tw = value[DW_W-1:0];
      REG_DST_HEIGHT: reg_th = value[SIDE_W-1:0];
      REG_CHANNELS:   reg_ch = value[CH_W-1:0];
      default: ;
    endcase
    restart_frame();
  endtask

  // sender holds off until every request is taken and every result is back
  task automatic drain();
    while (items_sent < items_queued) @(posedge clk);
    while (expected_pixels.size() > 0) @(posedge clk);
    // a trailing pixel with no result may still be in the pipeline
    repeat (30) @(posedge clk);
  endtask

  task automatic set_geometry(int sw, int sh, int tw, int th, int ch);
    reg_write(REG_SRC_WIDTH, sw);
    reg_write(REG_SRC_HEIGHT, sh);
    reg_write(REG_DST_WIDTH, tw);
    reg_write(REG_DST_HEIGHT, th);
    reg_write(REG_CHANNELS, ch);
  endtask

  task automatic queue_pixel(logic [31:0] v);
    src_pixel_t p;
    {p.alpha, p.blue, p.green, p.red} = v;
    pending_pixels.push_back(p);
    items_queued++;
  endtask

  initial begin
    int n;
    restart_frame();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // one-pixel image: every pixel is a whole frame, zero sizes clamp to one
    set_geometry(0, 0, 0, 0, 7);
    queue_pixel(32'h0000_0000);
    queue_pixel(32'hFFFF_FFFF);
    queue_pixel(32'hAA55_AA55);
    queue_pixel(32'h55AA_55AA);
    drain();
    // channel count below four: alpha ignored and forced opaque
    set_geometry(1, 1, 1, 1, 0);
    queue_pixel(32'h0012_3456);
    queue_pixel(32'hFF80_7F01);
    drain();

    // enlarging request clamps to the source: 4x2 source asked for 127x1023
    set_geometry(4, 2, 127, 1023, 4);
    for (int i = 0; i < 8; i++) queue_pixel($urandom);
    drain();

    // widest destination: oversized target width clamps to 64 columns
    set_geometry(64, 1, 127, 1, 3);
    for (int i = 0; i < 64; i++) queue_pixel(i[0] ? 32'hFFFF_FFFF : 32'h0);
    drain();

    // random geometries, some frames cut short by the next register write
    for (int g = 0; g < 3; g++) begin
      int sw, sh;
      sw = $urandom_range(1, 6);
      sh = $urandom_range(1, 4);
      set_geometry(sw, sh, $urandom_range(0, 8), $urandom_range(0, 5),
                   $urandom_range(0, 7));
      n = sw * sh + $urandom_range(0, sw);
      for (int i = 0; i < n; i++) queue_pixel($urandom);
      drain();
    end

    // final stretch with both sides always willing
    calm = 1'b1;
    set_geometry(6, 4, 3, 2, 4);
    for (int i = 0; i < 24; i++) queue_pixel($urandom);
    drain();

    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
